@@ hdl/pahp_pkg.sv @@
package pahp_pkg;

	// request table size; the slot is taken modulo this
	localparam int REQUEST_SLOTS = 256;

	// byte positions at which a 32-bit word is complete
	localparam logic [4:0] POS_WORD0 = 5'd3;
	localparam logic [4:0] POS_WORD1 = 5'd7;
	localparam logic [4:0] POS_WORD2 = 5'd11;
	localparam logic [4:0] POS_WORD3 = 5'd15;
	localparam logic [4:0] POS_WORD4 = 5'd19;

	// header lengths in bytes
	localparam logic [4:0] HDR_LEN_8  = 5'd8;
	localparam logic [4:0] HDR_LEN_12 = 5'd12;
	localparam logic [4:0] HDR_LEN_16 = 5'd16;
	localparam logic [4:0] HDR_LEN_20 = 5'd20;

	// play types
	localparam logic [1:0] MODE_RESIDENT = 2'd0;
	localparam logic [1:0] MODE_STREAM   = 2'd1;
	localparam logic [1:0] MODE_HYBRID   = 2'd2;
	localparam logic [1:0] MODE_RSVD     = 2'd3;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       first_byte;
		logic [7:0] request_slot;
	} pahp_in_t;

	typedef struct packed {
		logic [7:0]         slot_out;
		logic [3:0]         codec_id;
		logic [6:0]         channel_count;
		logic [17:0]        sample_rate_hz;
		logic [1:0]         play_mode;
		logic               loop_enabled;
		logic [28:0]        sample_total;
		logic signed [31:0] loop_begin;
		logic signed [31:0] resident_samples;
		logic signed [31:0] loop_stream_offset;
		logic [4:0]         header_length;
	} pahp_out_t;

endpackage

@@ hdl/pahp_in_stage.sv @@
module pahp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pahp_pkg::pahp_in_t in_data,
	input  logic               advance,
	output logic               valid_s1,
	output pahp_pkg::pahp_in_t data_s1
);
	import pahp_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

@@ hdl/pahp_parse_core.sv @@
module pahp_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  pahp_pkg::pahp_in_t  item,
	output logic                res_valid,
	output pahp_pkg::pahp_out_t res_data
);
	import pahp_pkg::*;

	logic [4:0]  pos_q, pos_n;
	logic [31:0] coll_q, coll_n;
	logic [7:0]  slot_q, slot_n;
	logic [3:0]  codec_q, codec_n;
	logic [6:0]  chan_q, chan_n;
	logic [17:0] rate_q, rate_n;
	logic [1:0]  mode_q, mode_n;
	logic        flag_q, flag_n;
	logic [28:0] count_q, count_n;
	logic [31:0] lbeg_q, lbeg_n;
	logic [31:0] resid_q, resid_n;
	logic        active_q, active_n;
	logic [31:0] w;
	logic [31:0] stream_ofs;
	logic [4:0]  hdr_len;
	logic        done;
	logic        loop2;
	logic [7:0]  slot_mod;

	assign slot_mod = 8'(32'(item.request_slot) % REQUEST_SLOTS);

	always_comb begin
		pos_n      = pos_q;
		coll_n     = coll_q;
		slot_n     = slot_q;
		codec_n    = codec_q;
		chan_n     = chan_q;
		rate_n     = rate_q;
		mode_n     = mode_q;
		flag_n     = flag_q;
		count_n    = count_q;
		lbeg_n     = lbeg_q;
		resid_n    = resid_q;
		active_n   = active_q;
		done       = 1'b0;
		stream_ofs = '0;
		hdr_len    = HDR_LEN_8;
		w          = {coll_q[23:0], item.header_byte};
		loop2      = flag_q && (mode_q == MODE_HYBRID);

		if (take) begin
			if (item.first_byte) begin
				active_n = 1'b1;
				pos_n    = '0;
				coll_n   = '0;
				slot_n   = slot_mod;
				lbeg_n   = '1;
				resid_n  = '0;
			end
			if (active_n) begin
				w      = {coll_n[23:0], item.header_byte};
				coll_n = w;
				pos_n  = pos_n + 5'd1;
				unique case (pos_n - 5'd1)
					POS_WORD0: begin
						codec_n = w[27:24];
						chan_n  = 7'(w[23:18]) + 7'd1;
						rate_n  = w[17:0];
					end
					POS_WORD1: begin
						mode_n  = w[31:30];
						flag_n  = w[29];
						count_n = w[28:0];
						if (!w[29] && w[31:30] != MODE_HYBRID) begin
							done    = 1'b1;
							hdr_len = HDR_LEN_8;
						end
					end
					POS_WORD2: begin
						hdr_len = HDR_LEN_12;
						if (flag_q) begin
							lbeg_n = w;
							done   = (mode_q == MODE_RESIDENT) || (mode_q == MODE_RSVD);
						end else begin
							resid_n = w;
							done    = 1'b1;
						end
					end
					POS_WORD3: begin
						hdr_len = HDR_LEN_16;
						if (loop2) begin
							resid_n = w;
							done    = $signed(lbeg_n) < $signed(w);
						end else begin
							stream_ofs = w;
							done       = 1'b1;
						end
					end
					POS_WORD4: begin
						hdr_len    = HDR_LEN_20;
						stream_ofs = w;
						done       = 1'b1;
					end
					default: begin
						if ((pos_n - 5'd1) > POS_WORD4) begin
							active_n = 1'b0;
						end
					end
				endcase
				if (done) begin
					active_n = 1'b0;
					pos_n    = '0;
				end
			end
		end
	end

	assign res_valid = done;

	always_comb begin
		res_data.slot_out           = slot_n;
		res_data.codec_id           = codec_n;
		res_data.channel_count      = chan_n;
		res_data.sample_rate_hz     = rate_n;
		res_data.play_mode          = mode_n;
		res_data.loop_enabled       = flag_n;
		res_data.sample_total       = count_n;
		res_data.loop_begin         = lbeg_n;
		res_data.resident_samples   = resid_n;
		res_data.loop_stream_offset = stream_ofs;
		res_data.header_length      = hdr_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			coll_q   <= '0;
			slot_q   <= '0;
			codec_q  <= '0;
			chan_q   <= 7'd1;
			rate_q   <= '0;
			mode_q   <= '0;
			flag_q   <= 1'b0;
			count_q  <= '0;
			lbeg_q   <= '1;
			resid_q  <= '0;
			active_q <= 1'b0;
		end else begin
			pos_q    <= pos_n;
			coll_q   <= coll_n;
			slot_q   <= slot_n;
			codec_q  <= codec_n;
			chan_q   <= chan_n;
			rate_q   <= rate_n;
			mode_q   <= mode_n;
			flag_q   <= flag_n;
			count_q  <= count_n;
			lbeg_q   <= lbeg_n;
			resid_q  <= resid_n;
			active_q <= active_n;
		end
	end

endmodule

@@ hdl/pahp_out_stage.sv @@
module pahp_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pahp_pkg::pahp_out_t res_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pahp_pkg::pahp_out_t out_data
);
	import pahp_pkg::*;

	logic out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= res_data;
		end
	end

endmodule

@@ hdl/packed_audio_header_parser_unit.sv @@
// Packed audio header parser.
// Input channel (in_valid/in_ready/in_data): one header byte per transfer,
// MSB first. first_byte marks the start of a header, restarts any parse in
// progress and samples request_slot. Bytes arriving with no parse active
// are dropped without a result.
// Output channel (out_valid/out_ready/out_data): one transfer per complete
// header, carrying the decoded fields and header_length (8, 12, 16 or 20),
// which is also the payload byte offset.
// Result path: a header's last byte is registered in the input register on
// its transfer, and its decoded result in the result register when the
// byte moves on, which waits while a full result register is not drained.
// Throughput: one byte per cycle, sustained, as long as out_ready is high;
// each byte only shifts into a 32-bit collector and hits a position decode.
// Stall: when the result register is full and out_ready is low, the byte in
// the input register holds and in_ready drops once that register is also
// occupied; nothing is lost or repeated.
// Reset (arst_n low): no parse active, both registers empty, held fields at
// their defaults (channels 1, loop start -1, everything else zero).
module packed_audio_header_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pahp_pkg::pahp_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pahp_pkg::pahp_out_t out_data
);
	import pahp_pkg::*;

	logic      valid_s1;
	pahp_in_t  data_s1;
	logic      advance;
	logic      res_valid;
	pahp_out_t res_data;

	// the byte in stage 1 moves on only when the result register can take a
	// result this cycle (empty, or being drained)
	assign advance = valid_s1 && (!out_valid || out_ready);

	pahp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	// header state and field decode
	pahp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.item      (data_s1),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	pahp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res_data  (res_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Header parser testbench: random byte streams of well-formed, truncated and
// noise headers go in, and every decoded result is checked against a predictor.
module tb_top;
	import pahp_pkg::*;

	// Parse predictor plus the queue of headers still waiting to come out.
	class header_scoreboard;
		logic [4:0]  pos_r;
		logic [31:0] collector;
		logic [7:0]  slot_h;
		logic [3:0]  codec_h;
		logic [6:0]  chan_h;
		logic [17:0] rate_h;
		logic [1:0]  mode_h;
		logic        loop_h;
		logic [28:0] count_h;
		logic [31:0] lbegin_h;
		logic [31:0] resid_h;
		bit          active;
		pahp_out_t   pending_headers[$];
		int          errors;

		function new();
			pos_r     = '0;
			collector = '0;
			slot_h    = '0;
			codec_h   = '0;
			chan_h    = 7'd1;
			rate_h    = '0;
			mode_h    = MODE_RESIDENT;
			loop_h    = 1'b0;
			count_h   = '0;
			lbegin_h  = '1;
			resid_h   = '0;
			active    = 1'b0;
			errors    = 0;
		endfunction

		function void close_header(logic [31:0] soffset, logic [4:0] len);
			pahp_out_t h;
			h.slot_out           = slot_h;
			h.codec_id           = codec_h;
			h.channel_count      = chan_h;
			h.sample_rate_hz     = rate_h;
			h.play_mode          = mode_h;
			h.loop_enabled       = loop_h;
			h.sample_total       = count_h;
			h.loop_begin         = lbegin_h;
			h.resident_samples   = resid_h;
			h.loop_stream_offset = soffset;
			h.header_length      = len;
			pending_headers.push_back(h);
			active = 1'b0;
			pos_r  = '0;
		endfunction

		// Called for every input transfer.
		function void take_byte(pahp_in_t b);
			logic [4:0]  pos;
			logic [31:0] w;
			bit          hybrid_loop;
			if (b.first_byte) begin
				active    = 1'b1;
				pos_r     = '0;
				collector = '0;
				slot_h    = b.request_slot;
				lbegin_h  = '1;
				resid_h   = '0;
			end
			if (!active)
				return;
			pos         = pos_r;
			collector   = {collector[23:0], b.header_byte};
			w           = collector;
			pos_r       = pos + 5'd1;
			hybrid_loop = loop_h && (mode_h == MODE_HYBRID);
			case (pos)
				POS_WORD0: begin
					codec_h = w[27:24];
					chan_h  = {1'b0, w[23:18]} + 7'd1;
					rate_h  = w[17:0];
				end
				POS_WORD1: begin
					mode_h  = w[31:30];
					loop_h  = w[29];
					count_h = w[28:0];
					if (!loop_h && mode_h != MODE_HYBRID)
						close_header('0, HDR_LEN_8);
				end
				POS_WORD2: begin
					if (loop_h) begin
						lbegin_h = w;
						if (mode_h == MODE_RESIDENT || mode_h == MODE_RSVD)
							close_header('0, HDR_LEN_12);
					end else begin
						resid_h = w;
						close_header('0, HDR_LEN_12);
					end
				end
				POS_WORD3: begin
					if (hybrid_loop) begin
						resid_h = w;
						if ($signed(lbegin_h) < $signed(resid_h))
							close_header('0, HDR_LEN_16);
					end else begin
						close_header(w, HDR_LEN_16);
					end
				end
				POS_WORD4: close_header(w, HDR_LEN_20);
				default: begin
					if (pos > POS_WORD4)
						active = 1'b0;
				end
			endcase
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			end
		endfunction

		// Called for every output transfer.
		function void check_header(pahp_out_t got);
			pahp_out_t want;
			if (pending_headers.size() == 0) begin
				errors++;
				$display("%0t: result expected none got slot %h length %0d", $time,
					got.slot_out, got.header_length);
				return;
			end
			want = pending_headers.pop_front();
			check_field("slot_out", want.slot_out, got.slot_out);
			check_field("codec_id", want.codec_id, got.codec_id);
			check_field("channel_count", want.channel_count, got.channel_count);
			check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
			check_field("play_mode", want.play_mode, got.play_mode);
			check_field("loop_enabled", want.loop_enabled, got.loop_enabled);
			check_field("sample_total", want.sample_total, got.sample_total);
			check_field("loop_begin", want.loop_begin, got.loop_begin);
			check_field("resident_samples", want.resident_samples, got.resident_samples);
			check_field("loop_stream_offset", want.loop_stream_offset,
				got.loop_stream_offset);
			check_field("header_length", want.header_length, got.header_length);
		endfunction
	endclass

	localparam int STALL_LIMIT = 2000;   // cycles without any transfer
	localparam int LONG_HOLD   = 80;     // receiver hold-off, enough to back up the input

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	pahp_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	pahp_out_t out_data;

	header_scoreboard sb = new();

	bit burst;          // when set, neither side takes a random gap or stall
	bit hold_long;      // request for one long receiver hold-off
	int header_bytes;   // bytes sent as part of headers (noise not counted)

	packed_audio_header_parser_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Monitors sample pre-edge values, so both transfers of an edge are seen
	// in a consistent state. A header's result is registered only after its
	// last byte has passed the input register, so the byte is always noted first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_byte(in_data);
			if (out_valid && out_ready)
				sb.check_header(out_data);
		end
	end

	// Watchdog: ends the run if no transfer happens for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: a random stall before each result, none during bursts,
	// and a long hold-off on request while the sender keeps pushing bytes.
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 3);
			if (hold_long) begin
				stall     = LONG_HOLD;
				hold_long = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// One byte transfer. Valid is only dropped when a gap is taken, so a
	// back-to-back byte never sees valid lowered and raised in one step.
	task automatic send_byte(input logic [7:0] hb, input logic fb, input logic [7:0] slot);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {hb, fb, slot};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Number of 32-bit words a well-formed header carries for these fields.
	function automatic int header_words(logic [1:0] mode, logic loop_on,
		logic [31:0] lbegin, logic [31:0] resid);
		int n;
		n = 2;
		if (loop_on)
			n++;
		if (mode == MODE_HYBRID)
			n++;
		if (loop_on && (mode == MODE_STREAM ||
			(mode == MODE_HYBRID && $signed(lbegin) >= $signed(resid))))
			n++;
		return n;
	endfunction

	// Sends a header built from the fields; cut > 0 stops after that many bytes.
	task automatic send_header(input logic [7:0] slot, input logic [3:0] version,
		input logic [3:0] codec, input logic [5:0] ch, input logic [17:0] rate,
		input logic [1:0] mode, input logic loop_on, input logic [28:0] count,
		input logic [31:0] lbegin, input logic [31:0] resid,
		input logic [31:0] soffset, input int cut);
		logic [31:0] words[5];
		logic [31:0] wv;
		int          nwords;
		int          nbytes;
		nwords   = 2;
		words[0] = {version, codec, ch, rate};
		words[1] = {mode, loop_on, count};
		if (loop_on)
			words[nwords++] = lbegin;
		if (mode == MODE_HYBRID)
			words[nwords++] = resid;
		if (header_words(mode, loop_on, lbegin, resid) > nwords)
			words[nwords++] = soffset;
		nbytes = (cut > 0) ? cut : 4 * nwords;
		for (int i = 0; i < nbytes; i++) begin
			wv = words[i / 4] >> (8 * (3 - (i % 4)));
			send_byte(wv[7:0], i == 0, (i == 0) ? slot : 8'($urandom_range(0, 255)));
		end
		header_bytes += nbytes;
	endtask

	// Random header; broken ones stop short and get restarted by the next one.
	task automatic random_header(input bit broken);
		logic [1:0]  mode;
		logic        loop_on;
		logic [31:0] lbegin;
		logic [31:0] resid;
		int          cut;
		mode    = 2'($urandom_range(0, 3));
		loop_on = 1'($urandom_range(0, 1));
		lbegin  = $urandom();
		resid   = ($urandom_range(0, 3) == 0) ? lbegin : $urandom();
		cut     = broken ? $urandom_range(1, 4 * header_words(mode, loop_on, lbegin, resid) - 1)
			: 0;
		send_header(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
			18'($urandom_range(0, 262143)), mode, loop_on, 29'($urandom()),
			lbegin, resid, $urandom(), cut);
	endtask

	initial begin
		int iter;
		int pick;
		int n;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		burst        = 1'b0;
		hold_long    = 1'b0;
		header_bytes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stray byte with no parse active is dropped.
		send_byte(8'hA5, 1'b0, 8'h3C);
		// Header abandoned after three bytes, then restarted by the next.
		send_header(8'h00, 4'h0, 4'h0, 6'h00, 18'h0, MODE_HYBRID, 1'b1, 29'h0,
			32'h0, 32'h0, 32'h0, 3);
		// Short resident header, no loop, every other fixed field at its maximum, top slot.
		send_header(8'hFF, 4'hF, 4'hF, 6'h3F, 18'h3FFFF, MODE_RESIDENT, 1'b0,
			29'h1FFF_FFFF, 32'h0, 32'h0, 32'h0, 0);
		// Looping reserved play type, most negative loop start.
		send_header(8'h80, 4'h5, 4'h0, 6'h00, 18'h0, MODE_RSVD, 1'b1, 29'h0,
			32'h8000_0000, 32'h0, 32'h0, 0);

		// Random: mostly well-formed headers, some truncated, some noise.
		iter = 0;
		while (header_bytes < 1500) begin
			burst = ($urandom_range(0, 7) == 0);
			if (iter == 5 || iter == 60)
				hold_long = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				n = $urandom_range(1, 4);
				repeat (n)
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
						8'($urandom_range(0, 255)));
			end else begin
				random_header(pick == 1);
			end
			iter++;
		end
		in_valid <= 1'b0;
		burst     = 1'b0;

		// Drain, then wait so that anything stray from the pipeline can still show.
		while (sb.pending_headers.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
